### sv/slbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the serial loaded bank mapper.
// Depends on nothing; every other file of the block imports it.
package slbm_pkg;

  // Field widths of the bus words.
  localparam int REQ_W       = 2;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int SEL_W       = 2;
  localparam int MADDR_W     = 18;
  localparam int MIRROR_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  // Register and shifter widths.
  localparam int SHIFT_W     = 5;
  localparam int SHIFT_CNT_W = 3;
  localparam int PRG_MODE_W  = 2;
  localparam int PRG_BANK_W  = 4;
  localparam int CHR_BANK_W  = 5;
  localparam int PRG_OFS_W   = 14;
  localparam int CHR_OFS_W   = 12;

  // Parameter defaults for the top level.
  localparam int PRG_BANK_BITS_DEF     = 4;
  localparam int CHR_RAM_ADDR_BITS_DEF = 15;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_CPU_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CPU_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PPU_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_PPU_WRITE = 2'd3;

  // Memory select codes.
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_PRG  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_CHR  = 2'd2;

  // Serial register targets, from CPU address bits 14..13.
  localparam logic [1:0] TGT_CTRL = 2'd0;
  localparam logic [1:0] TGT_CHR0 = 2'd1;
  localparam logic [1:0] TGT_CHR1 = 2'd2;
  localparam logic [1:0] TGT_PRG  = 2'd3;

  // PRG modes.
  localparam logic [PRG_MODE_W-1:0] PRG_MODE_32K_A     = 2'd0;
  localparam logic [PRG_MODE_W-1:0] PRG_MODE_32K_B     = 2'd1;
  localparam logic [PRG_MODE_W-1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [PRG_MODE_W-1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // CHR modes.
  localparam logic CHR_MODE_8K = 1'b0;
  localparam logic CHR_MODE_4K = 1'b1;

  // Mirroring codes.
  localparam logic [MIRROR_W-1:0] MIRROR_HORIZONTAL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM     = 1'b1;

  // Shifter count at which the next write commits.
  localparam logic [SHIFT_CNT_W-1:0] SHIFT_LAST = 3'd4;

  // Configuration held by the block.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] prg_bank_count;
    logic                  chr_is_ram;
  } slbm_cfg_t;

  // Mapper registers loaded through the shifter.
  typedef struct packed {
    logic [MIRROR_W-1:0]   mirror_sel;
    logic                  chr_mode;
    logic [PRG_MODE_W-1:0] prg_mode;
    logic [CHR_BANK_W-1:0] chr_bank_lo;
    logic [CHR_BANK_W-1:0] chr_bank_hi;
    logic [PRG_BANK_W-1:0] prg_bank;
  } slbm_state_t;

  // One CPU register write headed for the shifter.
  typedef struct packed {
    logic              en;
    logic [1:0]        target;
    logic [DATA_W-1:0] data;
  } slbm_wr_t;

  // Memory access computed for one word.
  typedef struct packed {
    logic [SEL_W-1:0]   mem_select;
    logic [MADDR_W-1:0] mapped_address;
    logic               chr_write_enable;
    logic [DATA_W-1:0]  chr_write_data;
  } slbm_map_t;

endpackage

### sv/slbm_if.sv
`timescale 1ns / 1ps
// Handshake channels of the bank mapper: request, result and configuration.
// Depends on slbm_pkg for field widths.

// Bus request channel.
interface slbm_in_if import slbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source(output valid, req_type, address, write_data, input ready);
  modport sink(input valid, req_type, address, write_data, output ready);
endinterface

// Mapped access result channel.
interface slbm_out_if import slbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEL_W-1:0]    mem_select;
  logic [MADDR_W-1:0]  mapped_address;
  logic                chr_write_enable;
  logic [DATA_W-1:0]   chr_write_data;
  logic [MIRROR_W-1:0] mirroring_mode;
  logic                mirroring_changed;

  modport source(output valid, mem_select, mapped_address, chr_write_enable,
                 chr_write_data, mirroring_mode, mirroring_changed, input ready);
  modport sink(input valid, mem_select, mapped_address, chr_write_enable,
               chr_write_data, mirroring_mode, mirroring_changed, output ready);
endinterface

// Configuration write channel.
interface slbm_cfg_if import slbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/slbm_regs.sv
`timescale 1ns / 1ps
// Serial load shifter, mapper registers and configuration registers.
// Depends on slbm_pkg and the configuration channel in slbm_if.
module slbm_regs import slbm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  slbm_cfg_if.sink           cfg_bus,
  input  slbm_wr_t           wr,
  output slbm_cfg_t          cfg,
  output slbm_state_t        state,
  output logic               ctrl_commit,
  output logic [MIRROR_W-1:0] mirror_next
);

  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [SHIFT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0]     value;
  slbm_state_t            state_r, state_nxt;
  slbm_cfg_t              cfg_r, cfg_nxt;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_PRG_BANK_COUNT: cfg_nxt.prg_bank_count = cfg_bus.data;
        CFG_CHR_IS_RAM:     cfg_nxt.chr_is_ram     = cfg_bus.data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // The incoming bit enters the shifter from the top; the fifth write commits.
  assign value = {wr.data[0], shift_r[SHIFT_W-1:1]};

  always_comb begin
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    state_nxt   = state_r;
    ctrl_commit = 1'b0;
    if (wr.en) begin
      if (wr.data[DATA_W-1]) begin
        // A reset write empties the shifter and fixes the last PRG bank.
        shift_nxt          = '0;
        cnt_nxt            = '0;
        state_nxt.prg_mode = PRG_MODE_FIX_LAST;
      end else if (cnt_r == SHIFT_LAST) begin
        shift_nxt = '0;
        cnt_nxt   = '0;
        case (wr.target)
          TGT_CTRL: begin
            state_nxt.mirror_sel = value[1:0];
            state_nxt.prg_mode   = value[3:2];
            state_nxt.chr_mode   = value[4];
            ctrl_commit          = 1'b1;
          end
          TGT_CHR0: state_nxt.chr_bank_lo = value;
          TGT_CHR1: state_nxt.chr_bank_hi = value;
          TGT_PRG:  state_nxt.prg_bank    = value[PRG_BANK_W-1:0];
          default:  state_nxt = state_r;
        endcase
      end else begin
        shift_nxt = value;
        cnt_nxt   = cnt_r + SHIFT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r                <= '0;
      cnt_r                  <= '0;
      state_r.mirror_sel     <= MIRROR_HORIZONTAL;
      state_r.chr_mode       <= CHR_MODE_4K;
      state_r.prg_mode       <= PRG_MODE_FIX_LAST;
      state_r.chr_bank_lo    <= '0;
      state_r.chr_bank_hi    <= '0;
      state_r.prg_bank       <= '0;
      cfg_r.prg_bank_count   <= CFG_DATA_W'(16);
      cfg_r.chr_is_ram       <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      state_r <= state_nxt;
      cfg_r   <= cfg_nxt;
    end
  end

  assign state       = state_r;
  assign cfg         = cfg_r;
  assign mirror_next = state_nxt.mirror_sel;

  // The shifter never holds more than four pending bits.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SHIFT_LAST)
    else $error("shift count out of range");

  // A commit or a reset write leaves the shifter empty.
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && (wr.data[DATA_W-1] || cnt_r == SHIFT_LAST)
    |=> cnt_r == '0 && shift_r == '0)
    else $error("shifter not cleared");

  // A reset write forces the fixed-last PRG mode.
  a_reset_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && wr.data[DATA_W-1] |=> state_r.prg_mode == PRG_MODE_FIX_LAST)
    else $error("reset write did not force PRG mode");

endmodule

### sv/slbm_addr_map.sv
`timescale 1ns / 1ps
// Address translation of CPU PRG reads and PPU CHR accesses.
// Depends on slbm_pkg; purely combinational.
module slbm_addr_map import slbm_pkg::*; #(
  parameter int PRG_BANK_BITS     = PRG_BANK_BITS_DEF,
  parameter int CHR_RAM_ADDR_BITS = CHR_RAM_ADDR_BITS_DEF
) (
  input  slbm_cfg_t          cfg,
  input  slbm_state_t        state,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [ADDR_W-1:0]  address,
  input  logic [DATA_W-1:0]  write_data,
  output slbm_map_t          map
);

  localparam logic [PRG_BANK_W-1:0] PRG_LOW_MASK =
    PRG_BANK_W'((1 << PRG_BANK_BITS) - 1);
  localparam logic [MADDR_W-1:0] CHR_RAM_MASK =
    MADDR_W'((1 << CHR_RAM_ADDR_BITS) - 1);

  logic [CFG_DATA_W-1:0] count_m1;
  logic [PRG_BANK_W-1:0] prg_mask;
  logic                  upper;
  logic [PRG_BANK_W-1:0] prg_bank_sel;
  logic [MADDR_W-1:0]    prg_addr;
  logic [MADDR_W-1:0]    chr_raw;
  logic [MADDR_W-1:0]    chr_addr;
  logic                  cpu_rom;
  logic                  ppu_chr;

  // Bank wrap mask; it also names the fixed last bank.
  assign count_m1 = cfg.prg_bank_count - CFG_DATA_W'(1);
  assign prg_mask = count_m1[PRG_BANK_W-1:0] & PRG_LOW_MASK;
  assign upper    = address[15] & address[14];

  // PRG bank selection by mode.
  always_comb begin
    case (state.prg_mode)
      PRG_MODE_32K_A, PRG_MODE_32K_B:
        prg_bank_sel = {state.prg_bank[PRG_BANK_W-1:1], upper};
      PRG_MODE_FIX_FIRST:
        prg_bank_sel = upper ? state.prg_bank : '0;
      PRG_MODE_FIX_LAST:
        prg_bank_sel = upper ? prg_mask : state.prg_bank;
      default:
        prg_bank_sel = state.prg_bank;
    endcase
  end

  assign prg_addr = {prg_bank_sel & prg_mask, address[PRG_OFS_W-1:0]};

  // CHR offset: one 8 KB window, or two 4 KB windows split on address bit 12.
  always_comb begin
    if (state.chr_mode == CHR_MODE_8K) begin
      chr_raw = MADDR_W'({state.chr_bank_lo[CHR_BANK_W-1:1], address[CHR_OFS_W:0]});
    end else if (!address[CHR_OFS_W]) begin
      chr_raw = MADDR_W'({state.chr_bank_lo, address[CHR_OFS_W-1:0]});
    end else begin
      chr_raw = MADDR_W'({state.chr_bank_hi, address[CHR_OFS_W-1:0]});
    end
  end

  assign chr_addr = cfg.chr_is_ram ? (chr_raw & CHR_RAM_MASK) : chr_raw;

  // Address range checks: PRG at 8000h and up, pattern tables below 2000h.
  assign cpu_rom = address[15];
  assign ppu_chr = (address[15:13] == 3'd0);

  always_comb begin
    map = '0;
    case (req_type)
      REQ_CPU_READ: begin
        if (cpu_rom) begin
          map.mem_select     = SEL_PRG;
          map.mapped_address = prg_addr;
        end
      end
      REQ_PPU_READ: begin
        if (ppu_chr) begin
          map.mem_select     = SEL_CHR;
          map.mapped_address = chr_addr;
        end
      end
      REQ_PPU_WRITE: begin
        if (ppu_chr && cfg.chr_is_ram) begin
          map.mem_select       = SEL_CHR;
          map.mapped_address   = chr_addr;
          map.chr_write_enable = 1'b1;
          map.chr_write_data   = write_data;
        end
      end
      default: map = '0;
    endcase
  end

endmodule

### sv/serial_loaded_bank_mapper.sv
`timescale 1ns / 1ps
// Top level of the serial loaded bank mapper: request register, translation
// and result register. Depends on slbm_pkg, slbm_if, slbm_regs and slbm_addr_map.
//
// The mapper takes one bus access per clock unless a held result stalls the
// input, and returns one result word for each. The request is registered at
// acceptance, translated against the bank registers in one pass of shallow
// logic, and registered again at the result port. Register writes through the
// five-write serial shifter take effect for the very next request. While a
// result waits, the request register still takes one more word; after that
// the input stalls until the result is taken. Configuration is written
// through its own port while the block is idle; the user is bound to this,
// and the block itself does not enforce it.
module serial_loaded_bank_mapper import slbm_pkg::*; #(
  parameter int PRG_BANK_BITS     = PRG_BANK_BITS_DEF,
  parameter int CHR_RAM_ADDR_BITS = CHR_RAM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slbm_in_if.sink     in_bus,
  slbm_out_if.source  out_bus,
  slbm_cfg_if.sink    cfg_bus
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [REQ_W-1:0]    s1_type_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [DATA_W-1:0]   s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  slbm_map_t           out_map_r;
  logic [MIRROR_W-1:0] out_mirror_r;
  logic                out_changed_r;
  logic                advance;
  logic                accept;
  slbm_wr_t            wr;
  slbm_cfg_t           cfg;
  slbm_state_t         state;
  logic                ctrl_commit;
  logic [MIRROR_W-1:0] mirror_next;
  slbm_map_t           map;

  // Handshake: the request word moves on when the result register frees up.
  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;
  assign accept       = in_bus.valid && in_bus.ready;

  assign s1_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  // Register writes go to the shifter only for addresses at 8000h and up.
  assign wr.en     = advance && (s1_type_r == REQ_CPU_WRITE) && s1_addr_r[15];
  assign wr.target = s1_addr_r[14:13];
  assign wr.data   = s1_data_r;

  slbm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_bus     (cfg_bus),
    .wr          (wr),
    .cfg         (cfg),
    .state       (state),
    .ctrl_commit (ctrl_commit),
    .mirror_next (mirror_next)
  );

  slbm_addr_map #(
    .PRG_BANK_BITS     (PRG_BANK_BITS),
    .CHR_RAM_ADDR_BITS (CHR_RAM_ADDR_BITS)
  ) u_addr_map (
    .cfg        (cfg),
    .state      (state),
    .req_type   (s1_type_r),
    .address    (s1_addr_r),
    .write_data (s1_data_r),
    .map        (map)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type_r <= in_bus.req_type;
      s1_addr_r <= in_bus.address;
      s1_data_r <= in_bus.write_data;
    end
    if (advance) begin
      out_map_r     <= map;
      out_mirror_r  <= mirror_next;
      out_changed_r <= ctrl_commit;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.mem_select        = out_map_r.mem_select;
  assign out_bus.mapped_address    = out_map_r.mapped_address;
  assign out_bus.chr_write_enable  = out_map_r.chr_write_enable;
  assign out_bus.chr_write_data    = out_map_r.chr_write_data;
  assign out_bus.mirroring_mode    = out_mirror_r;
  assign out_bus.mirroring_changed = out_changed_r;

  // A control commit comes from a register write, which touches no memory.
  a_commit_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.mirroring_changed |-> out_bus.mem_select == SEL_NONE)
    else $error("control commit with memory access");

  // CHR writes always target CHR memory.
  a_write_is_chr: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.chr_write_enable |-> out_bus.mem_select == SEL_CHR)
    else $error("CHR write outside CHR memory");

  // A word with no access carries a zero offset and no write.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.mem_select == SEL_NONE
    |-> out_bus.mapped_address == '0 && !out_bus.chr_write_enable)
    else $error("idle access carries an address");

endmodule
